[sv/uer_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// Register indexes, reset values, phase codes, configuration and result types.
// ----------------------------------------------------------------------------
package uer_pkg;

	localparam int STAMP_BITS = 16;
	localparam int CAPT_BITS  = 16;
	localparam int WIDTH_BITS = ((STAMP_BITS > 16) ? STAMP_BITS : 16) + 1;
	localparam int SCALE_BITS = 16;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] CFG_TIMER_PERIOD  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_Q16     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_TICKS   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FAIL_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GLITCH_WINDOW = 3'd4;

	localparam logic [15:0] RST_TIMER_PERIOD  = 16'd65535;
	localparam logic [15:0] RST_SCALE_Q16     = 16'd1206;
	localparam logic [15:0] RST_FRAME_TICKS   = 16'd2000;
	localparam logic [7:0]  RST_FAIL_LIMIT    = 8'd30;
	localparam logic [7:0]  RST_GLITCH_WINDOW = 8'd10;

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_START     = 3'd1,
		PH_END       = 3'd2,
		PH_WAIT_FALL = 3'd3,
		PH_GLITCH    = 3'd4
	} phase_t;

	typedef struct packed {
		logic [15:0]           timer_period;
		logic [SCALE_BITS-1:0] scale_q16;
		logic [15:0]           frame_ticks;
		logic [7:0]            fail_limit;
		logic [7:0]            glitch_window;
	} cfg_t;

	typedef struct packed {
		logic       trigger_level;
		logic [7:0] distance;
		logic       distance_new;
		logic       range_error;
	} result_t;

endpackage
`default_nettype wire

[sv/uer_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_cfg_regs: configuration register file
// Holds the five ranging registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module uer_cfg_regs (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 wr_en,
	input  wire [uer_pkg::CFG_IDX_BITS-1:0]     wr_index,
	input  wire [uer_pkg::CFG_DATA_BITS-1:0]    wr_data,
	output uer_pkg::cfg_t                       cfg
);
	import uer_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timer_period  <= RST_TIMER_PERIOD;
			cfg_q.scale_q16     <= RST_SCALE_Q16;
			cfg_q.frame_ticks   <= RST_FRAME_TICKS;
			cfg_q.fail_limit    <= RST_FAIL_LIMIT;
			cfg_q.glitch_window <= RST_GLITCH_WINDOW;
		end else if (wr_en) begin
			case (wr_index)
				CFG_TIMER_PERIOD:  cfg_q.timer_period  <= wr_data[15:0];
				CFG_SCALE_Q16:     cfg_q.scale_q16     <= wr_data[SCALE_BITS-1:0];
				CFG_FRAME_TICKS:   cfg_q.frame_ticks   <= wr_data[15:0];
				CFG_FAIL_LIMIT:    cfg_q.fail_limit    <= wr_data[7:0];
				CFG_GLITCH_WINDOW: cfg_q.glitch_window <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[sv/uer_range_calc.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_range_calc: echo width to distance
// Unwraps the width across timer rollover, scales by Q0.16 and saturates.
// ----------------------------------------------------------------------------
module uer_range_calc (
	input  wire [uer_pkg::STAMP_BITS-1:0] rise_stamp,
	input  wire [uer_pkg::STAMP_BITS-1:0] fall_stamp,
	input  wire [15:0]                    timer_period,
	input  wire [uer_pkg::SCALE_BITS-1:0] scale_q16,
	output logic [7:0]                    distance
);
	import uer_pkg::*;

	logic [WIDTH_BITS-1:0]            rise_w;
	logic [WIDTH_BITS-1:0]            fall_w;
	logic [WIDTH_BITS-1:0]            period_w;
	logic [WIDTH_BITS-1:0]            head;
	logic [WIDTH_BITS-1:0]            echo_width;
	logic [WIDTH_BITS+SCALE_BITS-1:0] product;
	logic [WIDTH_BITS-1:0]            scaled;

	always_comb begin
		rise_w   = WIDTH_BITS'(rise_stamp);
		fall_w   = WIDTH_BITS'(fall_stamp);
		period_w = WIDTH_BITS'(timer_period);
		head     = (period_w > rise_w) ? (period_w - rise_w) : '0;
		echo_width = (fall_w > rise_w) ? (fall_w - rise_w) : (head + fall_w);
		product  = (WIDTH_BITS+SCALE_BITS)'(echo_width)
		         * (WIDTH_BITS+SCALE_BITS)'(scale_q16);
		scaled   = product[WIDTH_BITS+SCALE_BITS-1:SCALE_BITS];
		distance = (|scaled[WIDTH_BITS-1:8]) ? COUNT_MAX : scaled[7:0];
	end

endmodule
`default_nettype wire

[sv/uer_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uer_step: ranging state and per-beat update
// Frame counter, trigger phase machine, echo capture and fail tracking.
// ----------------------------------------------------------------------------
module uer_step (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire uer_pkg::cfg_t           cfg,
	input  wire                          accept,
	input  wire                          command,
	input  wire [uer_pkg::CAPT_BITS-1:0] capture_time,
	output uer_pkg::result_t             result
);
	import uer_pkg::*;

	phase_t                phase_q, phase_n, phase_eff;
	logic [15:0]           tick_q, tick_n, tick_inc;
	logic [7:0]            fail_q, fail_n;
	logic [7:0]            win_q, win_n, win_inc;
	logic [STAMP_BITS-1:0] rise_q, rise_n;
	logic [STAMP_BITS-1:0] fall_q, fall_n;
	logic [STAMP_BITS-1:0] stamp;
	logic                  exp_rise_q, exp_rise_n;
	logic                  fall_seen_q, fall_seen_n;
	logic                  eaf_q, eaf_n;
	logic [7:0]            dist_q, dist_n;
	logic                  err_q, err_n;
	logic                  got_dist;
	logic                  frame_start;
	logic [7:0]            meas;

	uer_range_calc u_calc (
		.rise_stamp   (rise_q),
		.fall_stamp   (fall_q),
		.timer_period (cfg.timer_period),
		.scale_q16    (cfg.scale_q16),
		.distance     (meas)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			tick_q      <= '0;
			fail_q      <= '0;
			win_q       <= '0;
			rise_q      <= '0;
			fall_q      <= '0;
			exp_rise_q  <= 1'b1;
			fall_seen_q <= 1'b0;
			eaf_q       <= 1'b0;
			dist_q      <= '0;
			err_q       <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_n;
			tick_q      <= tick_n;
			fail_q      <= fail_n;
			win_q       <= win_n;
			rise_q      <= rise_n;
			fall_q      <= fall_n;
			exp_rise_q  <= exp_rise_n;
			fall_seen_q <= fall_seen_n;
			eaf_q       <= eaf_n;
			dist_q      <= dist_n;
			err_q       <= err_n;
		end
	end

	always_comb begin
		phase_n     = phase_q;
		tick_n      = tick_q;
		fail_n      = fail_q;
		win_n       = win_q;
		rise_n      = rise_q;
		fall_n      = fall_q;
		exp_rise_n  = exp_rise_q;
		fall_seen_n = fall_seen_q;
		eaf_n       = eaf_q;
		dist_n      = dist_q;
		err_n       = err_q;
		got_dist    = 1'b0;
		stamp       = STAMP_BITS'(capture_time);
		tick_inc    = tick_q + 16'd1;
		frame_start = (tick_inc >= cfg.frame_ticks);
		win_inc     = (win_q < COUNT_MAX) ? (win_q + 8'd1) : win_q;
		phase_eff   = phase_q;

		if (command) begin
			if (exp_rise_q) begin
				exp_rise_n = 1'b0;
				rise_n     = stamp;
				eaf_n      = 1'b1;
			end else begin
				exp_rise_n  = 1'b1;
				fall_seen_n = 1'b1;
				fall_n      = stamp;
				eaf_n       = 1'b0;
			end
		end else begin
			tick_n = tick_inc;
			if (frame_start) begin
				tick_n    = '0;
				phase_eff = PH_START;
				fail_n    = (fail_q < COUNT_MAX) ? (fail_q + 8'd1) : fail_q;
				err_n     = (fail_n > cfg.fail_limit);
			end
			phase_n = phase_eff;
			case (phase_eff)
				PH_START: begin
					exp_rise_n  = 1'b1;
					fall_seen_n = 1'b0;
					phase_n     = PH_END;
				end
				PH_END: phase_n = PH_WAIT_FALL;
				PH_WAIT_FALL: begin
					if (fall_seen_q) begin
						fall_seen_n = 1'b0;
						win_n       = '0;
						phase_n     = PH_GLITCH;
					end
				end
				PH_GLITCH: begin
					win_n = win_inc;
					if (win_inc > cfg.glitch_window) begin
						if (!eaf_q) begin
							dist_n   = meas;
							fail_n   = '0;
							got_dist = 1'b1;
						end
						phase_n = PH_IDLE;
					end
				end
				default: ;
			endcase
		end

		result.trigger_level = (phase_n == PH_END);
		result.distance      = dist_n;
		result.distance_new  = got_dist;
		result.range_error   = err_n;
	end

endmodule
`default_nettype wire

[sv/ultrasonic_echo_ranger.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: trigger and echo pulse-width ranging
// Frames of ticks start a measurement; captured echo edges give a distance.
//
//   channel  handshake             payload
//   item     item_valid/stall      command, capture_time
//   result   result_valid/stall    trigger_level, distance, distance_new,
//                                  range_error
//   cfg      cfg_valid/ready       cfg_index, cfg_data
//
// One beat per cycle while item_stall is low; each item's result is registered.
// The state update and distance scaling (one 17x16 multiply)
// sit between the state registers and the result register.
// A two-entry output register/skid pair holds results while result_stall is
// high; item_stall rises only when both entries are full.
// Reset is asynchronous; cfg_ready is always high.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              item_valid,
	output logic                             item_stall,
	input  wire                              command,
	input  wire [uer_pkg::CAPT_BITS-1:0]     capture_time,
	output logic                             result_valid,
	input  wire                              result_stall,
	output logic                             trigger_level,
	output logic [7:0]                       distance,
	output logic                             distance_new,
	output logic                             range_error,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [uer_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire [uer_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import uer_pkg::*;

	cfg_t    cfg;
	result_t step_res;
	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    accept, pop;

	assign cfg_ready = 1'b1;
	assign accept    = item_valid & ~skid_valid_q;
	assign pop       = out_valid_q & ~result_stall;

	uer_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	uer_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.accept       (accept),
		.command      (command),
		.capture_time (capture_time),
		.result       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (!out_valid_q || pop) begin
				out_q <= step_res;
			end else begin
				skid_q <= step_res;
			end
		end
	end

	assign item_stall    = skid_valid_q;
	assign result_valid  = out_valid_q;
	assign trigger_level = out_q.trigger_level;
	assign distance      = out_q.distance;
	assign distance_new  = out_q.distance_new;
	assign range_error   = out_q.range_error;

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ultrasonic_echo_ranger
// Drives ticks and echo captures with random gaps and result stalls and
// predicts every result beat from an in-bench model of the ranging state.
// Register settings change between phases, only once the block has drained.
// Directed tests run first, then a fail-count saturation run, then random
// measurement frames over many settings.
// ----------------------------------------------------------------------------
module testbench;
	import uer_pkg::*;

	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_CAPTURE = 1'b1;
	localparam int unsigned QUIET_LIMIT = 3000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        command = CMD_TICK;
	logic [15:0] capture_time = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        trigger_level;
	logic [7:0]  distance;
	logic        distance_new;
	logic        range_error;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_TIMER_PERIOD;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	ultrasonic_echo_ranger u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.command       (command),
		.capture_time  (capture_time),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.trigger_level (trigger_level),
		.distance      (distance),
		.distance_new  (distance_new),
		.range_error   (range_error),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ranging model state
	cfg_t        model_cfg = '{RST_TIMER_PERIOD, RST_SCALE_Q16, RST_FRAME_TICKS,
	                           RST_FAIL_LIMIT, RST_GLITCH_WINDOW};
	cfg_t        cur_cfg   = '{RST_TIMER_PERIOD, RST_SCALE_Q16, RST_FRAME_TICKS,
	                           RST_FAIL_LIMIT, RST_GLITCH_WINDOW};
	phase_t      stage = PH_START;
	logic [15:0] tick_n = '0;
	logic [7:0]  miss_n = '0;
	logic [7:0]  hold_n = '0;
	logic [15:0] t_rise = '0;
	logic [15:0] t_fall = '0;
	logic        want_rise = 1'b1;
	logic        fell = 1'b0;
	logic        late_edge = 1'b0;
	logic [7:0]  dist_q = '0;
	logic        err_q = 1'b0;

	result_t     awaited_readings[$];

	bit          gap_on = 1'b1;
	bit          stall_on = 1'b1;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned failures = 0;
	int unsigned items_sent = 0;
	int unsigned readings_checked = 0;
	int unsigned distances_seen = 0;
	int unsigned error_beats = 0;
	int unsigned settings_applied = 0;

	function automatic result_t next_reading(input logic cmd, input logic [15:0] stamp);
		result_t     r;
		logic [16:0] span;
		logic [32:0] prod;
		logic        took;
		took = 1'b0;
		if (cmd == CMD_CAPTURE) begin
			if (want_rise) begin
				want_rise = 1'b0;
				t_rise = stamp;
				late_edge = 1'b1;
			end else begin
				want_rise = 1'b1;
				fell = 1'b1;
				t_fall = stamp;
				late_edge = 1'b0;
			end
		end else begin
			tick_n = tick_n + 16'd1;
			if (tick_n >= model_cfg.frame_ticks) begin
				tick_n = '0;
				stage = PH_START;
				if (miss_n != COUNT_MAX)
					miss_n = miss_n + 8'd1;
				err_q = (miss_n > model_cfg.fail_limit);
			end
			case (stage)
			PH_START: begin
				want_rise = 1'b1;
				fell = 1'b0;
				stage = PH_END;
			end
			PH_END: begin
				stage = PH_WAIT_FALL;
			end
			PH_WAIT_FALL: begin
				if (fell) begin
					fell = 1'b0;
					hold_n = '0;
					stage = PH_GLITCH;
				end
			end
			PH_GLITCH: begin
				if (hold_n != COUNT_MAX)
					hold_n = hold_n + 8'd1;
				if (hold_n > model_cfg.glitch_window) begin
					if (!late_edge) begin
						if (t_fall > t_rise)
							span = {1'b0, t_fall} - {1'b0, t_rise};
						else
							span = ((model_cfg.timer_period > t_rise) ?
								{1'b0, model_cfg.timer_period - t_rise} : 17'd0) +
								{1'b0, t_fall};
						prod = span * model_cfg.scale_q16;
						dist_q = (prod[32:16] > 17'd255) ? COUNT_MAX : prod[23:16];
						miss_n = '0;
						took = 1'b1;
					end
					stage = PH_IDLE;
				end
			end
			default: begin
			end
			endcase
		end
		r.trigger_level = (stage == PH_END);
		r.distance = dist_q;
		r.distance_new = took;
		r.range_error = err_q;
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
			CFG_TIMER_PERIOD:  model_cfg.timer_period = cfg_data;
			CFG_SCALE_Q16:     model_cfg.scale_q16 = cfg_data;
			CFG_FRAME_TICKS:   model_cfg.frame_ticks = cfg_data;
			CFG_FAIL_LIMIT:    model_cfg.fail_limit = cfg_data[7:0];
			CFG_GLITCH_WINDOW: model_cfg.glitch_window = cfg_data[7:0];
			default: begin
			end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			awaited_readings.push_back(next_reading(command, capture_time));
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			readings_checked++;
			if (distance_new === 1'b1)
				distances_seen++;
			if (range_error === 1'b1)
				error_beats++;
			if (awaited_readings.size() == 0) begin
				$display("%0t: result beat with no expected reading, distance %0d",
					$time, distance);
				failures++;
			end else begin
				want = awaited_readings.pop_front();
				compare_field("trigger_level", want.trigger_level, trigger_level);
				compare_field("distance", want.distance, distance);
				compare_field("distance_new", want.distance_new, distance_new);
				compare_field("range_error", want.range_error, range_error);
			end
		end
	end

	// result-side back-pressure
	always @(posedge clk) begin
		int unsigned sel;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			sel = $urandom_range(0, 99);
			if (!stall_on || sel < 50) begin
				result_stall <= 1'b0;
				stall_left <= $urandom_range(0, 8);
			end else if (sel < 92) begin
				result_stall <= 1'b1;
				stall_left <= $urandom_range(0, 2);
			end else begin
				result_stall <= 1'b1;
				stall_left <= $urandom_range(10, 30);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
			(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_item(input logic cmd, input logic [15:0] stamp);
		int unsigned sel;
		int unsigned n;
		item_valid <= 1'b1;
		command <= cmd;
		capture_time <= stamp;
		do @(posedge clk); while (item_stall);
		items_sent++;
		sel = $urandom_range(0, 99);
		n = 0;
		if (gap_on) begin
			if (sel >= 92)
				n = $urandom_range(10, 30);
			else if (sel >= 60)
				n = $urandom_range(1, 3);
		end
		if (n != 0) begin
			item_valid <= 1'b0;
			command <= 1'($urandom);
			capture_time <= 16'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (awaited_readings.size() != 0);
	endtask

	task automatic quiesce();
		wait_drain();
		repeat (2) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_config(input cfg_t c);
		quiesce();
		cfg_valid <= 1'b1;
		put_reg(CFG_TIMER_PERIOD, c.timer_period);
		put_reg(CFG_SCALE_Q16, c.scale_q16);
		put_reg(CFG_FRAME_TICKS, c.frame_ticks);
		put_reg(CFG_FAIL_LIMIT, {8'd0, c.fail_limit});
		put_reg(CFG_GLITCH_WINDOW, {8'd0, c.glitch_window});
		cfg_valid <= 1'b0;
		cur_cfg = c;
		settings_applied++;
	endtask

	task automatic run_traffic(input int unsigned quota);
		int unsigned stop_at;
		int unsigned sel;
		int unsigned lead;
		int unsigned tail;
		logic [15:0] rise;
		logic [15:0] fall;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			sel = $urandom_range(0, 99);
			lead = $urandom_range(0, (cur_cfg.frame_ticks > 12) ? 12 : cur_cfg.frame_ticks);
			repeat (lead) send_item(CMD_TICK, 16'($urandom));
			rise = 16'($urandom);
			case ($urandom_range(0, 4))
			0, 1:    fall = rise + 16'($urandom_range(1, 400));
			2:       fall = rise;
			3:       fall = rise - 16'($urandom_range(1, 400));
			default: fall = 16'($urandom);
			endcase
			tail = ((cur_cfg.glitch_window > 30) ? 30 : cur_cfg.glitch_window) + 2 +
				$urandom_range(0, 3);
			if (sel < 70) begin
				send_item(CMD_CAPTURE, rise);
				repeat ($urandom_range(0, 2)) send_item(CMD_TICK, 16'($urandom));
				send_item(CMD_CAPTURE, fall);
				repeat (tail) send_item(CMD_TICK, 16'($urandom));
			end else if (sel < 82) begin
				// echo edge after the fall: no distance for this frame, unless a second one follows
				send_item(CMD_CAPTURE, rise);
				send_item(CMD_CAPTURE, fall);
				repeat ($urandom_range(0, 2)) send_item(CMD_TICK, 16'($urandom));
				send_item(CMD_CAPTURE, 16'($urandom));
				if ($urandom_range(0, 1) == 0)
					send_item(CMD_CAPTURE, 16'($urandom));
				repeat (tail) send_item(CMD_TICK, 16'($urandom));
			end else if (sel < 90) begin
				send_item(CMD_CAPTURE, rise);
			end else begin
				repeat ($urandom_range(1, 6)) send_item(1'($urandom), 16'($urandom));
			end
		end
	endtask

	task automatic test_reset_values();
		send_item(CMD_TICK, 16'hFFFF);
		send_item(CMD_TICK, 16'h0000);
		send_item(CMD_CAPTURE, 16'h0000);
		send_item(CMD_CAPTURE, 16'hFFFF);
		repeat (12) send_item(CMD_TICK, 16'($urandom));
	endtask

	task automatic test_corner_cases();
		apply_config(cfg_t'{16'd1, 16'hFFFF, 16'd4, 8'd0, 8'd0});
		send_item(CMD_TICK, 16'h0000);
		send_item(CMD_CAPTURE, 16'h8000);
		send_item(CMD_CAPTURE, 16'h8000);
		repeat (3) send_item(CMD_TICK, 16'h5555);
		send_item(CMD_CAPTURE, 16'h0000);
		send_item(CMD_CAPTURE, 16'h0000);
		repeat (3) send_item(CMD_TICK, 16'hAAAA);
		send_item(CMD_CAPTURE, 16'h0010);
		send_item(CMD_CAPTURE, 16'h0020);
		send_item(CMD_CAPTURE, 16'h0030);
		repeat (6) send_item(CMD_TICK, 16'h0000);
		// frame on every tick, glitch window that never closes
		apply_config(cfg_t'{16'hFFFF, RST_SCALE_Q16, 16'd0, 8'd3, 8'd255});
		repeat (3) send_item(CMD_TICK, 16'h0000);
		send_item(CMD_CAPTURE, 16'd100);
		send_item(CMD_CAPTURE, 16'd50);
		repeat (4) send_item(CMD_TICK, 16'hFFFF);
	endtask

	task automatic test_high_settings();
		apply_config(cfg_t'{16'hFFFF, 16'd0, 16'hFFFF, 8'd254, 8'd254});
		send_item(CMD_TICK, 16'h0000);
		send_item(CMD_CAPTURE, 16'hFFFF);
		send_item(CMD_CAPTURE, 16'h0000);
		repeat (5) send_item(CMD_TICK, 16'h0000);
	endtask

	task automatic test_fail_saturation();
		apply_config(cfg_t'{16'd1000, 16'd40000, 16'd1, 8'd254, 8'd0});
		repeat (262) send_item(CMD_TICK, 16'($urandom));
		apply_config(cfg_t'{16'd1000, 16'd40000, 16'd6, 8'd254, 8'd0});
		run_traffic(80);
	endtask

	task automatic test_random_traffic();
		cfg_t        c;
		int unsigned r;
		for (int p = 0; p < 8; p++) begin
			r = $urandom_range(0, 9);
			c.timer_period = (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF :
				16'($urandom_range(1, 65535));
			r = $urandom_range(0, 9);
			c.scale_q16 = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
				16'($urandom_range(1, 65534));
			r = $urandom_range(0, 9);
			c.frame_ticks = (r == 0) ? 16'd2 : (r == 1) ? 16'hFFFF :
				16'($urandom_range(4, 40));
			r = $urandom_range(0, 9);
			c.fail_limit = (r == 0) ? 8'd0 : (r == 1) ? 8'd254 : 8'($urandom_range(0, 6));
			r = $urandom_range(0, 9);
			c.glitch_window = (r == 0) ? 8'd0 : (r == 1) ? 8'd254 :
				8'($urandom_range(0, 8));
			apply_config(c);
			gap_on = (p != 2);
			stall_on = (p != 2) && (p != 5);
			if (p == 4) begin
				run_traffic(80);
				wait_drain();
				run_traffic(80);
			end else begin
				run_traffic(160);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_corner_cases();
		test_high_settings();
		test_fail_saturation();
		test_random_traffic();
		wait_drain();
		repeat (4) @(posedge clk);
		if (awaited_readings.size() != 0) begin
			$display("%0t: %0d expected readings never arrived", $time,
				awaited_readings.size());
			failures++;
		end
		$display("Sent %0d items over %0d register settings; checked %0d result beats.",
			items_sent, settings_applied, readings_checked);
		$display("Distances taken: %0d; beats with range error raised: %0d; mismatches: %0d.",
			distances_seen, error_beats, failures);
		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[filelist.f]
sv/uer_pkg.sv
sv/uer_cfg_regs.sv
sv/uer_range_calc.sv
sv/uer_step.sv
sv/ultrasonic_echo_ranger.sv
bench/testbench.sv
